### rtl/erbrf_pkg.sv
// Package for the ERB resonator filterbank: sizes, payload and row types,
// state and operation codes, and the coefficient ROM computed at elaboration.
// Depends on nothing; erbrf_mul and the top module import it.
`default_nettype none

package erbrf_pkg;

   // Block sizes.
   localparam int CHANNELS    = 32;
   localparam int SAMPLE_BITS = 16;
   localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int DRIVE_SHIFT = SAMPLE_BITS + 1;

   // Digit-serial multiplier geometry: a 49-bit signed multiplicand times a
   // 32-bit signed multiplier, four multiplier bits per cycle.
   localparam int MUL_A_W    = 49;
   localparam int MUL_B_W    = 32;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
   localparam int MUL_DIGIT  = 4;
   localparam int MUL_STEPS  = MUL_B_W / MUL_DIGIT;
   localparam int MUL_CNT_W  = $clog2(MUL_STEPS);

   // Configuration register indexes.
   localparam logic [1:0] CSR_ENV_DECAY    = 2'd0;
   localparam logic [1:0] CSR_ENV_ALPHA    = 2'd1;
   localparam logic [1:0] CSR_ENERGY_FLOOR = 2'd2;

   localparam logic [15:0] ENV_DECAY_RESET    = 16'd52429;
   localparam logic [15:0] ENV_ALPHA_RESET    = 16'd13107;
   localparam logic [47:0] ENERGY_FLOOR_RESET = 48'd10995;

   // Fixed-point constants used to build the ROM (Q30).
   localparam longint Q30_ONE     = 64'sd1073741824;
   localparam longint PI_Q30      = 64'sd3373259426;
   localparam longint PI_HALF_Q30 = PI_Q30 / 2;
   localparam longint LN2_Q30     = 64'sd744261118;
   localparam longint LN_ULO_Q30  = 64'sd389293293;
   localparam longint LN_UHI_Q30  = 64'sd3846580452;
   localparam longint ROM_SPAN    = (CHANNELS > 1) ? longint'(CHANNELS - 1) : 64'sd1;

   // Payload types.
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last_in_frame;
   } req_type;

   typedef struct packed {
      logic [4:0]  channel;
      logic [47:0] peak_energy;
      logic        last_channel;
   } rsp_type;

   // One channel's persistent state as held in the state RAM.
   typedef struct packed {
      logic signed [31:0] stage_one_prev;
      logic signed [31:0] stage_one_prev_two;
      logic signed [31:0] stage_two_prev;
      logic signed [31:0] stage_two_prev_two;
      logic [47:0]        envelope;
      logic [47:0]        frame_peak;
   } row_type;

   localparam int ROW_W = $bits(row_type);

   typedef struct packed {
      logic signed [31:0] fb_one;
      logic signed [31:0] fb_two;
      logic signed [31:0] gain;
   } coef_type;

   typedef coef_type [CHANNELS-1:0] coef_rom_type;

   // Multiplier request and response.
   typedef struct packed {
      logic                       start;
      logic signed [MUL_A_W-1:0]  a;
      logic signed [MUL_B_W-1:0]  b;
   } mul_req_type;

   typedef struct packed {
      logic                       done;
      logic signed [MUL_P_W-1:0]  product;
   } mul_rsp_type;

   // Sequencer states and multiply operations of one channel update.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_MSTART,
      ST_MWAIT,
      ST_WRITE
   } state_type;

   typedef enum logic [3:0] {
      OP_DRIVE1,
      OP_FB1A,
      OP_FB1B,
      OP_DRIVE2,
      OP_FB2A,
      OP_FB2B,
      OP_SQUARE,
      OP_DECAY,
      OP_ALPHA
   } op_type;

   // Arithmetic shift right by s with rounding half up.
   function automatic longint erbrf_round_shift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   // Unsigned long division by shift and subtract; used only while the ROM
   // is built, where every quotient is of non-negative operands.
   function automatic longint unsigned erbrf_udiv(longint unsigned num,
                                                  longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      int              i;
      quo = '0;
      rem = '0;
      for (i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic signed [31:0] erbrf_sat32_l(longint v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end
      if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return 32'(v);
   endfunction

   function automatic logic signed [31:0] erbrf_sat32(logic signed [35:0] v);
      if (v > 36'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end
      if (v < -36'sd2147483648) begin
         return 32'sh80000000;
      end
      return 32'(v);
   endfunction

   // Exponential in Q30 by range reduction over ln 2 and a Taylor series.
   function automatic longint unsigned erbrf_exp_q30(longint x);
      longint            xv;
      int                k;
      int                n;
      longint unsigned   term;
      longint unsigned   sum;
      xv   = x;
      k    = 0;
      term = 64'(Q30_ONE);
      sum  = 64'(Q30_ONE);
      while (xv < 0) begin
         xv = xv + LN2_Q30;
         k  = k - 1;
      end
      while (xv >= LN2_Q30) begin
         xv = xv - LN2_Q30;
         k  = k + 1;
      end
      for (n = 1; n <= 24; n++) begin
         term = erbrf_udiv((term * 64'(xv)) >> 30, 64'(n));
         sum  = sum + term;
      end
      if (k >= 0) begin
         return sum << k;
      end
      return sum >> (-k);
   endfunction

   // Cosine in Q30 by folding into the first quadrant and a Taylor series.
   function automatic longint erbrf_cos_q30(longint t_in);
      logic   neg;
      longint t;
      longint t2;
      longint term;
      longint sum;
      longint n;
      neg  = 1'b0;
      t    = t_in;
      term = Q30_ONE;
      sum  = Q30_ONE;
      if (t < 0) begin
         t = -t;
      end
      if (t > PI_HALF_Q30) begin
         t   = PI_Q30 - t;
         neg = 1'b1;
      end
      if (t < 0) begin
         t = -t;
      end
      t2 = erbrf_round_shift(t * t, 30);
      for (n = 1; n <= 10; n++) begin
         term = longint'(erbrf_udiv(64'(erbrf_round_shift(term * t2, 30)),
                                    64'((2 * n - 1) * (2 * n))));
         sum  = n[0] ? sum - term : sum + term;
      end
      return neg ? -sum : sum;
   endfunction

   // Resonator coefficients for every channel, ERB-spaced centers.
   function automatic coef_rom_type erbrf_build_rom();
      coef_rom_type rom;
      longint       ln_u;
      longint       u;
      longint       theta;
      longint       arg;
      longint       r;
      longint       c;
      longint       om;
      int           ch;
      rom  = '0;
      for (ch = 0; ch < CHANNELS; ch++) begin
         ln_u  = LN_ULO_Q30 + longint'(erbrf_udiv(
                    64'((LN_UHI_Q30 - LN_ULO_Q30) * longint'(ch)), 64'(ROM_SPAN)));
         u     = longint'(erbrf_exp_q30(ln_u));
         theta = erbrf_round_shift(
                    longint'(erbrf_udiv(64'((u - Q30_ONE) * 100), 64'd3496)) * PI_Q30, 30);
         arg   = erbrf_round_shift(
                    longint'(erbrf_udiv(64'(u * 247), 64'd160000)) * PI_Q30, 30);
         r     = longint'(erbrf_exp_q30(-arg));
         c     = erbrf_cos_q30(theta);
         om    = Q30_ONE - r;
         rom[ch].fb_one = erbrf_sat32_l(-erbrf_round_shift(r * c, 29));
         rom[ch].fb_two = erbrf_sat32_l(erbrf_round_shift(r * r, 30));
         rom[ch].gain   = erbrf_sat32_l(erbrf_round_shift(om * om, 30));
      end
      return rom;
   endfunction

   localparam coef_rom_type COEF_ROM = erbrf_build_rom();

endpackage

`default_nettype wire

### rtl/erbrf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module erbrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/erbrf_mul.sv
// Digit-serial signed multiplier: consumes four multiplier bits per cycle.
// Depends on erbrf_pkg for widths and the request and response types.
`default_nettype none

module erbrf_mul (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire erbrf_pkg::mul_req_type req,
   output      erbrf_pkg::mul_rsp_type rsp
);

   import erbrf_pkg::*;

   logic signed [MUL_A_W-1:0] a_ff;
   logic [MUL_P_W-1:0]        prod_ff;
   logic [MUL_P_W-1:0]        prod_in;
   logic [MUL_CNT_W-1:0]      cnt_ff;
   logic                      run_ff;
   logic                      done_ff;
   logic                      last_step;
   logic signed [MUL_A_W-1:0] upper;
   logic signed [MUL_DIGIT:0] dig;
   logic signed [MUL_A_W+4:0] part;

   assign last_step = (cnt_ff == MUL_CNT_W'(MUL_STEPS - 1));

   // One step: add multiplicand times the low digit to the upper half, then
   // shift the pair right by one digit. The top digit carries the sign.
   always_comb begin
      upper = $signed(prod_ff[MUL_P_W-1:MUL_B_W]);
      if (last_step) begin
         dig = (MUL_DIGIT+1)'($signed(prod_ff[MUL_DIGIT-1:0]));
      end else begin
         dig = $signed({1'b0, prod_ff[MUL_DIGIT-1:0]});
      end
      part = (MUL_A_W+5)'(upper) + (MUL_A_W+5)'(a_ff) * (MUL_A_W+5)'(dig);
      prod_in = {part[MUL_A_W+3:0], prod_ff[MUL_B_W-1:MUL_DIGIT]};
   end

   // Operand and product registers.
   always_ff @(posedge clock) begin
      if (req.start) begin
         a_ff    <= req.a;
         prod_ff <= {MUL_A_W'(0), req.b};
      end else if (run_ff) begin
         prod_ff <= prod_in;
      end
   end

   // Step counter and completion flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= run_ff && last_step;
         if (req.start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + MUL_CNT_W'(1);
            if (last_step) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   assign rsp.done    = done_ff;
   assign rsp.product = $signed(prod_ff);

endmodule

`default_nettype wire

### rtl/erb_resonator_filterbank_envelope.sv
// ERB-spaced resonator filterbank with per-frame peak envelope energy. Each
// sample item is run through all channels one after another; every channel
// update is nine multiplies on one shared multiplier that takes four bits of
// the multiplier operand per cycle, plus a state RAM read and write. The
// input is ready only while the block is idle, so a new item is not taken
// before the last one is through all channels. On an item marked last in
// frame, each channel's floored peak leaves as a result item as soon as that
// channel is done, lowest channel first; a result that is not taken holds up
// the next channel. Depends on erbrf_pkg, erbrf_ram and erbrf_mul.
`default_nettype none

module erb_resonator_filterbank_envelope (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire erbrf_pkg::req_type req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      erbrf_pkg::rsp_type rsp_data,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [47:0]       csr_wdata
);

   import erbrf_pkg::*;

   localparam logic signed [MUL_P_W-1:0] HALF_DRIVE = MUL_P_W'(1) <<< (DRIVE_SHIFT - 1);
   localparam logic signed [MUL_P_W-1:0] HALF_Q30   = MUL_P_W'(1) <<< 29;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   logic [15:0] decay_ff;
   logic [15:0] alpha_ff;
   logic [47:0] floor_ff;

   logic [CH_W-1:0]               ch_ff, ch_in;
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic                          last_ff;
   logic [CHANNELS-1:0]           vld_ff;
   logic                          rv_ff;

   logic signed [31:0] s1p_ff, s1p_in, s1p2_ff, s1p2_in;
   logic signed [31:0] s2p_ff, s2p_in, s2p2_ff, s2p2_in;
   logic [47:0]        env_ff, env_in, peak_ff, peak_in;
   logic signed [35:0] acc_ff, acc_in;
   logic [46:0]        pw_ff, pw_in;
   logic [64:0]        eacc_ff, eacc_in;
   coef_type           coef_ff, coef_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   row_type            rd_row, wr_row;
   logic [ROW_W-1:0]   rd_bits;
   logic               ram_we, ram_re;

   mul_req_type        mreq;
   mul_rsp_type        mrsp;

   logic signed [MUL_P_W-1:0] rnd_drive, rnd_q30;
   logic signed [35:0]        acc_diff;
   logic signed [31:0]        y_sat;
   logic [63:0]               sq_round;
   logic [64:0]               esum;
   logic [47:0]               env_new;
   logic                      out_free;

   // Channel state RAM.
   erbrf_ram #(
      .WIDTH (ROW_W),
      .DEPTH (CHANNELS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ch_ff),
      .wr_data (wr_row),
      .rd_en   (ram_re),
      .rd_addr (ch_ff),
      .rd_data (rd_bits)
   );

   // Shared multiplier.
   erbrf_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mreq),
      .rsp   (mrsp)
   );

   // A row never written since reset reads as all zero.
   assign rd_row = rv_ff ? row_type'(rd_bits) : row_type'('0);

   // Rounded products and resonator sum.
   assign rnd_drive = (mrsp.product + HALF_DRIVE) >>> DRIVE_SHIFT;
   assign rnd_q30   = (mrsp.product + HALF_Q30) >>> 30;
   assign acc_diff  = acc_ff - 36'(rnd_q30);
   assign y_sat     = erbrf_sat32(acc_diff);
   assign sq_round  = 64'(mrsp.product) + 64'd32768;
   assign esum      = eacc_ff + 65'(mrsp.product[63:0]) + 65'd32768;
   assign env_new   = esum[64] ? '1 : esum[63:16];
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff <= ENV_DECAY_RESET;
         alpha_ff <= ENV_ALPHA_RESET;
         floor_ff <= ENERGY_FLOOR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ENV_DECAY:    decay_ff <= csr_wdata[15:0];
            CSR_ENV_ALPHA:    alpha_ff <= csr_wdata[15:0];
            CSR_ENERGY_FLOOR: floor_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Multiplier operands for each operation.
   always_comb begin
      mreq.start = (state_ff == ST_MSTART);
      mreq.a     = MUL_A_W'(coef_ff.gain);
      mreq.b     = MUL_B_W'(x_ff);
      unique case (op_ff)
         OP_DRIVE1: begin
            mreq.a = MUL_A_W'(coef_ff.gain);
            mreq.b = MUL_B_W'(x_ff);
         end
         OP_FB1A: begin
            mreq.a = MUL_A_W'(coef_ff.fb_one);
            mreq.b = s1p_ff;
         end
         OP_FB1B: begin
            mreq.a = MUL_A_W'(coef_ff.fb_two);
            mreq.b = s1p2_ff;
         end
         OP_DRIVE2: begin
            mreq.a = MUL_A_W'(coef_ff.gain);
            mreq.b = s1p_ff;
         end
         OP_FB2A: begin
            mreq.a = MUL_A_W'(coef_ff.fb_one);
            mreq.b = s2p_ff;
         end
         OP_FB2B: begin
            mreq.a = MUL_A_W'(coef_ff.fb_two);
            mreq.b = s2p2_ff;
         end
         OP_SQUARE: begin
            mreq.a = MUL_A_W'(s2p_ff);
            mreq.b = s2p_ff;
         end
         OP_DECAY: begin
            mreq.a = $signed(MUL_A_W'(env_ff));
            mreq.b = $signed(MUL_B_W'(decay_ff));
         end
         OP_ALPHA: begin
            mreq.a = $signed(MUL_A_W'(pw_ff));
            mreq.b = $signed(MUL_B_W'(alpha_ff));
         end
         default: ;
      endcase
   end

   // Sequencer: next state, datapath updates and result loading.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      ch_in        = ch_ff;
      s1p_in       = s1p_ff;
      s1p2_in      = s1p2_ff;
      s2p_in       = s2p_ff;
      s2p2_in      = s2p2_ff;
      env_in       = env_ff;
      peak_in      = peak_ff;
      acc_in       = acc_ff;
      pw_in        = pw_ff;
      eacc_in      = eacc_ff;
      coef_in      = coef_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      ram_re       = 1'b0;
      ram_we       = 1'b0;
      req_ready    = 1'b0;

      wr_row.stage_one_prev     = s1p_ff;
      wr_row.stage_one_prev_two = s1p2_ff;
      wr_row.stage_two_prev     = s2p_ff;
      wr_row.stage_two_prev_two = s2p2_ff;
      wr_row.envelope           = env_ff;
      wr_row.frame_peak         = last_ff ? 48'd0 : peak_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ch_in     = '0;
            if (req_valid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            ram_re   = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            s1p_in   = rd_row.stage_one_prev;
            s1p2_in  = rd_row.stage_one_prev_two;
            s2p_in   = rd_row.stage_two_prev;
            s2p2_in  = rd_row.stage_two_prev_two;
            env_in   = rd_row.envelope;
            peak_in  = rd_row.frame_peak;
            coef_in  = COEF_ROM[ch_ff];
            op_in    = OP_DRIVE1;
            state_in = ST_MSTART;
         end
         ST_MSTART: begin
            state_in = ST_MWAIT;
         end
         ST_MWAIT: begin
            if (mrsp.done) begin
               state_in = ST_MSTART;
               unique case (op_ff)
                  OP_DRIVE1: begin
                     acc_in = 36'(rnd_drive);
                     op_in  = OP_FB1A;
                  end
                  OP_FB1A: begin
                     acc_in = acc_diff;
                     op_in  = OP_FB1B;
                  end
                  OP_FB1B: begin
                     s1p2_in = s1p_ff;
                     s1p_in  = y_sat;
                     op_in   = OP_DRIVE2;
                  end
                  OP_DRIVE2: begin
                     acc_in = 36'(rnd_q30);
                     op_in  = OP_FB2A;
                  end
                  OP_FB2A: begin
                     acc_in = acc_diff;
                     op_in  = OP_FB2B;
                  end
                  OP_FB2B: begin
                     s2p2_in = s2p_ff;
                     s2p_in  = y_sat;
                     op_in   = OP_SQUARE;
                  end
                  OP_SQUARE: begin
                     pw_in = sq_round[62:16];
                     op_in = OP_DECAY;
                  end
                  OP_DECAY: begin
                     eacc_in = 65'(mrsp.product[63:0]);
                     op_in   = OP_ALPHA;
                  end
                  OP_ALPHA: begin
                     env_in   = env_new;
                     peak_in  = (env_new > peak_ff) ? env_new : peak_ff;
                     state_in = ST_WRITE;
                  end
                  default: ;
               endcase
            end
         end
         ST_WRITE: begin
            // On the last sample of a frame the result item must find room.
            if (!last_ff || out_free) begin
               ram_we = 1'b1;
               if (last_ff) begin
                  rsp_valid_in             = 1'b1;
                  rsp_data_in.channel      = 5'(ch_ff);
                  rsp_data_in.peak_energy  = (peak_ff < floor_ff) ? floor_ff : peak_ff;
                  rsp_data_in.last_channel = (ch_ff == CH_W'(CHANNELS - 1));
               end
               if (ch_ff == CH_W'(CHANNELS - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  ch_in    = ch_ff + CH_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_DRIVE1;
         ch_ff        <= '0;
         vld_ff       <= '0;
         rv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ram_re) begin
            rv_ff <= vld_ff[ch_ff];
         end
         if (ram_we) begin
            vld_ff[ch_ff] <= 1'b1;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         x_ff    <= req_data.sample;
         last_ff <= req_data.last_in_frame;
      end
      s1p_ff      <= s1p_in;
      s1p2_ff     <= s1p2_in;
      s2p_ff      <= s2p_in;
      s2p2_ff     <= s2p2_in;
      env_ff      <= env_in;
      peak_ff     <= peak_in;
      acc_ff      <= acc_in;
      pw_ff       <= pw_in;
      eacc_ff     <= eacc_in;
      coef_ff     <= coef_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
